FILE: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/erot_pkg.sv
// types, constants and arithmetic helpers for the euler rotation transform
package erot_pkg;

    localparam int CORDIC_STAGES = 20;

    localparam logic signed [32:0] CORDIC_K    = 33'sd652032874;
    localparam logic signed [28:0] ANG_PI      = 29'sd52707179;
    localparam logic signed [28:0] ANG_HALF_PI = 29'sd26353589;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [28:0] z;
    } lane_t;

    typedef struct packed {
        logic               func;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
    } side_t;

    // one word of the cordic chain: lanes are roll, yaw, pitch
    typedef struct packed {
        side_t       side;
        logic [2:0]  neg;
        lane_t [2:0] lanes;
    } cstage_t;

    typedef logic signed [18:0] ent_t;
    typedef ent_t [2:0][2:0] mat_t;

    function automatic logic signed [28:0] atan_val(input int i);
        logic signed [28:0] r;
        case (i)
            0:       r = 29'sd13176795;
            1:       r = 29'sd7778716;
            2:       r = 29'sd4110060;
            3:       r = 29'sd2086331;
            4:       r = 29'sd1047214;
            5:       r = 29'sd524117;
            6:       r = 29'sd262123;
            7:       r = 29'sd131069;
            8:       r = 29'sd65536;
            9:       r = 29'sd32768;
            10:      r = 29'sd16384;
            11:      r = 29'sd8192;
            12:      r = 29'sd4096;
            13:      r = 29'sd2048;
            14:      r = 29'sd1024;
            15:      r = 29'sd512;
            16:      r = 29'sd256;
            17:      r = 29'sd128;
            18:      r = 29'sd64;
            default: r = 29'sd32;
        endcase
        return r;
    endfunction

    // q.30 product, rounded half up
    function automatic logic signed [32:0] mul30(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
        logic signed [65:0] p;
        p = a * b;
        p = p + 66'sd536870912;
        return p[62:30];
    endfunction

    // q.30 to q3.16, rounded half up
    function automatic ent_t rnd14(input logic signed [34:0] v);
        logic signed [34:0] t;
        t = v + 35'sd8192;
        return t[32:14];
    endfunction

endpackage

FILE: design/erot_cordic_cell.sv
// one rotation step of the cordic chain, three lanes wide
module erot_cordic_cell
    import erot_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  logic    valid_in,
    input  cstage_t d_in,
    output logic    valid_out,
    output cstage_t d_out
);

    localparam logic signed [28:0] ATAN = atan_val(IDX);

    logic    valid_reg;
    cstage_t d_reg, d_next;

    always_comb begin
        d_next = d_in;
        for (int k = 0; k < 3; k++) begin
            if (!d_in.lanes[k].z[28]) begin
                d_next.lanes[k].x = d_in.lanes[k].x - (d_in.lanes[k].y >>> IDX);
                d_next.lanes[k].y = d_in.lanes[k].y + (d_in.lanes[k].x >>> IDX);
                d_next.lanes[k].z = d_in.lanes[k].z - ATAN;
            end else begin
                d_next.lanes[k].x = d_in.lanes[k].x + (d_in.lanes[k].y >>> IDX);
                d_next.lanes[k].y = d_in.lanes[k].y - (d_in.lanes[k].x >>> IDX);
                d_next.lanes[k].z = d_in.lanes[k].z + ATAN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign valid_out = valid_reg;
    assign d_out     = d_reg;

endmodule

FILE: design/erot_matrix.sv
// two stages that build the rotation matrix from the sines and cosines
module erot_matrix
    import erot_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  logic    valid_in,
    input  cstage_t d_in,
    output logic    valid_out,
    output side_t   side_out,
    output mat_t    mat_out
);

    logic signed [32:0] c_v [3];
    logic signed [32:0] s_v [3];

    logic               v1_reg, v2_reg;
    side_t              side1_reg, side2_reg;
    logic signed [32:0] crsy_reg, srsy_reg, crcy_reg, srcp_reg, srsp_reg, crcp_reg;
    logic signed [32:0] srcy_reg, crsp_reg, cysp_reg, cycp_reg, sp_reg, cp_reg, sy_reg;
    mat_t               mat_reg, mat_next;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            c_v[k] = d_in.neg[k] ? -d_in.lanes[k].x : d_in.lanes[k].x;
            s_v[k] = d_in.neg[k] ? -d_in.lanes[k].y : d_in.lanes[k].y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    // lane 0 roll, lane 1 yaw, lane 2 pitch
    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg <= d_in.side;
            crsy_reg  <= mul30(c_v[0], s_v[1]);
            srsy_reg  <= mul30(s_v[0], s_v[1]);
            crcy_reg  <= mul30(c_v[0], c_v[1]);
            srcp_reg  <= mul30(s_v[0], c_v[2]);
            srsp_reg  <= mul30(s_v[0], s_v[2]);
            crcp_reg  <= mul30(c_v[0], c_v[2]);
            srcy_reg  <= mul30(s_v[0], c_v[1]);
            crsp_reg  <= mul30(c_v[0], s_v[2]);
            cysp_reg  <= mul30(c_v[1], s_v[2]);
            cycp_reg  <= mul30(c_v[1], c_v[2]);
            sp_reg    <= s_v[2];
            cp_reg    <= c_v[2];
            sy_reg    <= s_v[1];
            side2_reg <= side1_reg;
            mat_reg   <= mat_next;
        end
    end

    always_comb begin
        mat_next[0][0] = rnd14(35'(crcy_reg));
        mat_next[0][1] = rnd14(35'(mul30(crsy_reg, sp_reg)) - 35'(srcp_reg));
        mat_next[0][2] = rnd14(35'(srsp_reg) + 35'(mul30(crsy_reg, cp_reg)));
        mat_next[1][0] = rnd14(35'(srcy_reg));
        mat_next[1][1] = rnd14(35'(crcp_reg) + 35'(mul30(srsy_reg, sp_reg)));
        mat_next[1][2] = rnd14(35'(mul30(srsy_reg, cp_reg)) - 35'(crsp_reg));
        mat_next[2][0] = rnd14(-35'(sy_reg));
        mat_next[2][1] = rnd14(35'(cysp_reg));
        mat_next[2][2] = rnd14(35'(cycp_reg));
    end

    assign valid_out = v2_reg;
    assign side_out  = side2_reg;
    assign mat_out   = mat_reg;

endmodule

FILE: design/erot_vector.sv
// two stages that rotate and shift the vector, saturating to 32 bits
module erot_vector
    import erot_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               valid_in,
    input  side_t              side_in,
    input  mat_t               mat_in,
    output logic               valid_out,
    output logic               func_out,
    output mat_t               mat_out,
    output logic signed [31:0] res_out [3]
);

    logic               v1_reg, v2_reg;
    logic               func1_reg, func2_reg;
    mat_t               mat1_reg, mat2_reg;
    logic signed [31:0] tx_reg, ty_reg;
    logic signed [50:0] prod_reg [3][3];
    logic signed [31:0] res_reg [3];
    logic signed [31:0] res_next [3];
    logic signed [31:0] vin [3];
    logic signed [31:0] tin [3];

    assign vin[0] = side_in.vec_x;
    assign vin[1] = side_in.vec_y;
    assign vin[2] = side_in.vec_z;
    assign tin[0] = tx_reg;
    assign tin[1] = ty_reg;
    assign tin[2] = 32'sd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            func1_reg <= side_in.func;
            mat1_reg  <= mat_in;
            tx_reg    <= side_in.shift_x;
            ty_reg    <= side_in.shift_y;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    prod_reg[i][j] <= $signed(mat_in[i][j]) * vin[j];
                end
            end
            func2_reg <= func1_reg;
            mat2_reg  <= mat1_reg;
            for (int i = 0; i < 3; i++) begin
                res_reg[i] <= res_next[i];
            end
        end
    end

    always_comb begin
        logic signed [52:0] acc;
        logic signed [36:0] r;
        logic signed [37:0] w;
        for (int i = 0; i < 3; i++) begin
            acc = {{2{prod_reg[i][0][50]}}, prod_reg[i][0]}
                + {{2{prod_reg[i][1][50]}}, prod_reg[i][1]}
                + {{2{prod_reg[i][2][50]}}, prod_reg[i][2]};
            acc = acc + 53'sd32768;
            r   = acc[52:16];
            w   = {r[36], r} + {{6{tin[i][31]}}, tin[i]};
            if (w > 38'sd2147483647) begin
                res_next[i] = 32'sh7fffffff;
            end else if (w < -38'sd2147483648) begin
                res_next[i] = 32'sh80000000;
            end else begin
                res_next[i] = w[31:0];
            end
        end
    end

    assign valid_out = v2_reg;
    assign func_out  = func2_reg;
    assign mat_out   = mat2_reg;
    assign res_out   = res_reg;

endmodule

FILE: design/euler_rotation_transform.sv
// top level: angle reduction, cordic chain, matrix and vector stages, output words
// Each item takes three q3.13 angles and becomes either three matrix-row words
// (tuser 0, sign-extended q3.16 entries, tlast on the third row) or one transformed
// vector word (tuser 1, q16.16 saturated, tlast set). An item passes a reduction
// register, a chain of 20 cordic cells, two matrix stages, two vector stages and
// the output register. Vector items go at one a cycle while the output is not
// stalled; matrix items hold the output register for three words, so it takes the
// next item only once the third row is accepted. Back-pressure on the output
// stalls the whole pipeline at once while the last vector stage holds an item.
module euler_rotation_transform
    import erot_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // roll[15:0] yaw[31:16] pitch[47:32] vec_x vec_y vec_z shift_x shift_y (32 each)
    input  logic [207:0] s_axis_tdata,
    // func
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_a[31:0] out_b[63:32] out_c[95:64]
    output logic [95:0]  m_axis_tdata,
    output logic         m_axis_tlast
);

    logic    en;
    cstage_t pre_next, pre_reg;
    logic    pre_valid_reg;
    logic    cv [CORDIC_STAGES+1];
    cstage_t cd [CORDIC_STAGES+1];

    logic               mx_valid;
    side_t              mx_side;
    mat_t               mx_mat;
    logic               fin_valid, fin_func;
    mat_t               fin_mat;
    logic signed [31:0] fin_res [3];

    logic        ser_valid_reg, ser_func_reg;
    logic [1:0]  ser_cnt_reg;
    mat_t        ser_mat_reg;
    logic [95:0] ser_vec_reg;
    logic        word_done, ser_free;

    // input reduction into the half circle the cordic covers
    always_comb begin
        logic signed [15:0] ang;
        logic signed [28:0] z;
        pre_next.side.func    = s_axis_tuser;
        pre_next.side.vec_x   = s_axis_tdata[79:48];
        pre_next.side.vec_y   = s_axis_tdata[111:80];
        pre_next.side.vec_z   = s_axis_tdata[143:112];
        pre_next.side.shift_x = s_axis_tdata[175:144];
        pre_next.side.shift_y = s_axis_tdata[207:176];
        for (int k = 0; k < 3; k++) begin
            ang = s_axis_tdata[16*k +: 16];
            z   = {{2{ang[15]}}, ang, 11'd0};
            pre_next.neg[k] = 1'b0;
            if (z > ANG_HALF_PI) begin
                z = z - ANG_PI;
                pre_next.neg[k] = 1'b1;
            end else if (z < -ANG_HALF_PI) begin
                z = z + ANG_PI;
                pre_next.neg[k] = 1'b1;
            end
            pre_next.lanes[k].x = CORDIC_K;
            pre_next.lanes[k].y = 33'sd0;
            pre_next.lanes[k].z = z;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_valid_reg <= 1'b0;
        end else if (en) begin
            pre_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pre_reg <= pre_next;
        end
    end

    assign cv[0] = pre_valid_reg;
    assign cd[0] = pre_reg;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        erot_cordic_cell #(.IDX(g)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (cv[g]),
            .d_in      (cd[g]),
            .valid_out (cv[g+1]),
            .d_out     (cd[g+1])
        );
    end

    erot_matrix u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (cv[CORDIC_STAGES]),
        .d_in      (cd[CORDIC_STAGES]),
        .valid_out (mx_valid),
        .side_out  (mx_side),
        .mat_out   (mx_mat)
    );

    erot_vector u_vector (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (mx_valid),
        .side_in   (mx_side),
        .mat_in    (mx_mat),
        .valid_out (fin_valid),
        .func_out  (fin_func),
        .mat_out   (fin_mat),
        .res_out   (fin_res)
    );

    // output register: one word per vector item, three per matrix item
    assign word_done = m_axis_tvalid && m_axis_tready;
    assign ser_free  = !ser_valid_reg || (word_done && m_axis_tlast);
    assign en        = !fin_valid || ser_free;
    assign s_axis_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_valid_reg <= 1'b0;
            ser_cnt_reg   <= 2'd0;
        end else if (ser_free) begin
            ser_valid_reg <= fin_valid;
            ser_cnt_reg   <= 2'd0;
        end else if (word_done) begin
            ser_cnt_reg <= ser_cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ser_free) begin
            ser_func_reg <= fin_func;
            ser_mat_reg  <= fin_mat;
            ser_vec_reg  <= {fin_res[2], fin_res[1], fin_res[0]};
        end
    end

    always_comb begin
        logic [1:0] row;
        row = 2'd0;
        case (ser_cnt_reg)
            2'd1:    row = 2'd1;
            2'd2:    row = 2'd2;
            default: row = 2'd0;
        endcase
        if (ser_func_reg) begin
            m_axis_tdata = ser_vec_reg;
            m_axis_tlast = 1'b1;
        end else begin
            m_axis_tdata = {32'(ser_mat_reg[row][2]), 32'(ser_mat_reg[row][1]),
                            32'(ser_mat_reg[row][0])};
            m_axis_tdata = {{13{ser_mat_reg[row][2][18]}}, ser_mat_reg[row][2],
                            {13{ser_mat_reg[row][1][18]}}, ser_mat_reg[row][1],
                            {13{ser_mat_reg[row][0][18]}}, ser_mat_reg[row][0]};
            m_axis_tlast = (ser_cnt_reg == 2'd2);
        end
    end

    assign m_axis_tvalid = ser_valid_reg;

endmodule

FILE: design/erot_checker.sv
// port-level checks for the euler rotation transform, bound to the top level
`include "assert_macros.svh"

module erot_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic m_axis_tlast
);

    `ASSERT_CLK(a_out_hold, aclk, aresetn,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid,
        "output word dropped while stalled")
    `ASSERT_CLK(a_rows_follow, aclk, aresetn,
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid,
        "matrix row missing after a non-final row")
    `ASSERT_ALWAYS(a_rst_out, aclk, !aresetn |=> !m_axis_tvalid, "output valid after reset")
    `ASSERT_ALWAYS(a_rst_ready, aclk, !aresetn |=> s_axis_tready, "input not ready after reset")

endmodule

bind euler_rotation_transform erot_checker u_erot_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: bench/tb_euler_rotation_transform.sv
// testbench for the euler rotation transform: matrix rows and vector transform words
module tb_euler_rotation_transform;
    import erot_pkg::*;

    localparam logic OP_MATRIX = 1'b0;
    localparam logic OP_VECTOR = 1'b1;
    localparam int   PI_CODE   = 25736;
    localparam longint ATANS [20] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
        262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};

    typedef struct {
        logic [95:0] data;
        logic        last;
    } word_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [207:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [95:0]  m_axis_tdata;
    logic         m_axis_tlast;

    word_t  expected_words[$];
    int     errors = 0;
    longint cycles = 0;
    bit     send_idle_on = 1'b1;
    bit     recv_idle_on = 1'b1;
    int     hold_off = 0;

    euler_rotation_transform dut (.*);

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("euler_rotation_transform regression: fail");
            $finish;
        end
    end

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_by(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return round_by(a * b, 30);
    endfunction

    task automatic cordic_sincos(input logic signed [15:0] ang, output longint c,
                                 output longint s);
        longint z, x, y, nx;
        bit neg;
        z = longint'(ang) * 2048;
        x = 652032874;
        y = 0;
        neg = 0;
        if (z > 26353589) begin
            z -= 52707179; neg = 1;
        end else if (z < -26353589) begin
            z += 52707179; neg = 1;
        end
        for (int i = 0; i < 20; i++) begin
            if (z >= 0) begin
                nx = x - shr_floor(y, i); y = y + shr_floor(x, i); z -= ATANS[i];
            end else begin
                nx = x + shr_floor(y, i); y = y - shr_floor(x, i); z += ATANS[i];
            end
            x = nx;
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endtask

    task automatic predict_rotation(input logic func, input logic [207:0] d);
        longint cr, sr, cy, sy, cp, sp, crsy, srsy, acc;
        longint m[3][3];
        longint v[3];
        longint t[3];
        word_t w;
        cordic_sincos(d[15:0], cr, sr);
        cordic_sincos(d[31:16], cy, sy);
        cordic_sincos(d[47:32], cp, sp);
        crsy = qmul(cr, sy);
        srsy = qmul(sr, sy);
        m[0][0] = qmul(cr, cy);
        m[0][1] = qmul(crsy, sp) - qmul(sr, cp);
        m[0][2] = qmul(sr, sp) + qmul(crsy, cp);
        m[1][0] = qmul(sr, cy);
        m[1][1] = qmul(cr, cp) + qmul(srsy, sp);
        m[1][2] = qmul(srsy, cp) - qmul(cr, sp);
        m[2][0] = -sy;
        m[2][1] = qmul(cy, sp);
        m[2][2] = qmul(cy, cp);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = round_by(m[i][j], 14);
        if (func == OP_MATRIX) begin
            for (int i = 0; i < 3; i++) begin
                w.data = {m[i][2][31:0], m[i][1][31:0], m[i][0][31:0]};
                w.last = (i == 2);
                expected_words.push_back(w);
            end
        end else begin
            v[0] = longint'($signed(d[79:48]));
            v[1] = longint'($signed(d[111:80]));
            v[2] = longint'($signed(d[143:112]));
            t[0] = longint'($signed(d[175:144]));
            t[1] = longint'($signed(d[207:176]));
            t[2] = 0;
            for (int i = 0; i < 3; i++) begin
                acc = m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2];
                acc = round_by(acc, 16) + t[i];
                if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                if (acc < -64'sd2147483648) acc = -64'sd2147483648;
                w.data[i*32 +: 32] = acc[31:0];
            end
            w.last = 1'b1;
            expected_words.push_back(w);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [95:0] got,
                                   input logic [95:0] want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    // checker of output words
    always @(posedge aclk) begin
        word_t w;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tdata, '0);
            end else begin
                w = expected_words.pop_front();
                for (int k = 0; k < 3; k++)
                    if (m_axis_tdata[k*32 +: 32] !== w.data[k*32 +: 32])
                        report_mismatch($sformatf("out field %0d", k),
                                        m_axis_tdata, w.data);
                if (m_axis_tlast !== w.last)
                    report_mismatch("tlast", {95'd0, m_axis_tlast}, {95'd0, w.last});
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            m_axis_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            m_axis_tready <= !(recv_idle_on && $urandom_range(99) < 23);
        end
    end

    // valid drops only while idling, so words can follow back to back
    task automatic send_word(input logic func, input logic [207:0] d);
        while (send_idle_on && $urandom_range(99) < 23) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= func;
        s_axis_tdata <= d;
        predict_rotation(func, d);
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    function automatic logic [15:0] rand_angle();
        int a;
        a = $urandom_range(2 * PI_CODE) - PI_CODE;
        return a[15:0];
    endfunction

    function automatic logic [207:0] pack_item(logic [15:0] r, logic [15:0] y,
                                               logic [15:0] p, logic [159:0] rest);
        return {rest, p, y, r};
    endfunction

    function automatic logic [159:0] rand_rest(bit narrow);
        logic [159:0] r;
        for (int k = 0; k < 5; k++) begin
            r[k*32 +: 32] = $urandom();
            if (narrow) r[k*32 +: 32] = $signed(r[k*32 +: 20]);
        end
        return r;
    endfunction

    task automatic test_directed();
        logic [15:0] edges[6] = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868,
                                  -16'sd12868, 16'sd12869};
        foreach (edges[i]) begin
            send_word(OP_VECTOR ^ 1'b1,
                      pack_item(edges[i], edges[(i+1)%6], edges[(i+2)%6], '0));
            send_word(OP_VECTOR, pack_item(edges[i], edges[(i+2)%6], edges[(i+4)%6],
                      {5{32'h7fffffff}}));
        end
        send_word(OP_VECTOR, pack_item(16'd0, 16'd0, 16'd0, {5{32'h80000000}}));
        send_word(OP_VECTOR, pack_item(16'sd6000, 16'd0, 16'd0, {32'h7fffffff, 32'h80000000,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff}));
        send_word(OP_VECTOR, pack_item(16'd0, 16'sd9000, 16'd0, rand_rest(1'b0)));
        send_word(OP_MATRIX, pack_item(16'hffff, 16'h0001, 16'h8000 + 16'd7032, '0));
        send_word(OP_VECTOR, pack_item(16'sd100, -16'sd200, 16'sd300, {5{32'h00010000}}));
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
            send_word(1'($urandom_range(1)), pack_item(rand_angle(), rand_angle(),
                      rand_angle(), rand_rest(1'($urandom_range(1)))));
    endtask

    task automatic test_back_pressure();
        hold_off <= 150;
        for (int i = 0; i < 60; i++)
            send_word(1'($urandom_range(1)), pack_item(rand_angle(), rand_angle(),
                      rand_angle(), rand_rest(1'b0)));
    endtask

    task automatic test_streaming();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        test_random(50);
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(100);
        test_back_pressure();
        test_streaming();
        test_random(20);
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (errors == 0)
            $display("euler_rotation_transform regression: pass");
        else
            $display("euler_rotation_transform regression: fail");
        $finish;
    end

endmodule
